// File: src/acdke_pkg.sv
package acdke_pkg;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] RCON_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY    = 8'h1B;
	localparam logic [3:0] LAST_ROUND = 4'd10;
	localparam logic [3:0] MAX_REQ    = 4'd8;

	// configuration register indexes
	localparam logic CFG_KEY_LOW  = 1'b0;
	localparam logic CFG_KEY_HIGH = 1'b1;

	typedef struct packed {
		logic item_start;
		logic kx_seed;
		logic kx_new;
		logic kx_step;
		logic enc_begin;
		logic enc_step;
		logic take;
		logic set_cursor;
		logic set_rekeyed;
		logic out_load;
	} acdke_cmd_t;

	typedef struct packed {
		logic seeded;
		logic kx_last;
		logic enc_last;
		logic want_done;
		logic take_last;
		logic cursor_end;
		logic row_edge;
		logic out_free;
	} acdke_sts_t;

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [127:0] next_key(input logic [127:0] p, input logic [7:0] rc);
		logic [7:0] t [4];
		logic [127:0] k;
		t[0] = SBOX[p[13*8 +: 8]] ^ rc;
		t[1] = SBOX[p[14*8 +: 8]];
		t[2] = SBOX[p[15*8 +: 8]];
		t[3] = SBOX[p[12*8 +: 8]];
		for (int i = 0; i < 4; i++)
			k[i*8 +: 8] = p[i*8 +: 8] ^ t[i];
		for (int i = 4; i < 16; i++)
			k[i*8 +: 8] = p[i*8 +: 8] ^ k[(i-4)*8 +: 8];
		return k;
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[i + 4*c] = SBOX[s[(i + 4*((c + i) % 4))*8 +: 8]];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			al = a0 ^ a1 ^ a2 ^ a3;
			if (!last) begin
				t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++)
			r[i*8 +: 8] = t[i];
		return r;
	endfunction

endpackage

// File: src/acdke_ctrl.sv
module acdke_ctrl
	import acdke_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  acdke_sts_t sts,
	output acdke_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SEED  = 3'd1;
	localparam logic [2:0] S_KXS   = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_TAKE  = 3'd4;
	localparam logic [2:0] S_ENC   = 3'd5;
	localparam logic [2:0] S_KXR   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.item_start = 1'b1;
					state_d = sts.seeded ? S_CHECK : S_SEED;
				end
			end
			S_SEED: begin
				cmd.kx_seed = 1'b1;
				state_d = S_KXS;
			end
			S_KXS: begin
				cmd.kx_step = 1'b1;
				if (sts.kx_last)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.want_done) begin
					state_d = S_DONE;
				end else if (sts.cursor_end) begin
					cmd.enc_begin   = 1'b1;
					cmd.set_rekeyed = 1'b1;
					state_d = S_ENC;
				end else begin
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				cmd.take = 1'b1;
				if (sts.take_last)
					state_d = S_DONE;
				else if (sts.row_edge)
					state_d = S_CHECK;
			end
			S_ENC: begin
				cmd.enc_step = 1'b1;
				if (sts.enc_last)
					state_d = S_KXR;
			end
			S_KXR: begin
				// new key was loaded on the last refill cycle; ten expansion steps follow
				cmd.kx_step = 1'b1;
				if (sts.kx_last) begin
					cmd.set_cursor = 1'b1;
					state_d = S_CHECK;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (state_q == S_ENC && sts.enc_last)
			cmd.kx_new = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_take_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAKE |-> !sts.cursor_end) else $error("byte taken from empty buffer");
	a_take_needs_want: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAKE |-> !sts.want_done) else $error("byte taken beyond request");
	a_enc_to_kx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ENC && sts.enc_last |=> state_q == S_KXR) else $error("refill end lost");
`endif

endmodule

// File: src/acdke_dp.sv
module acdke_dp
	import acdke_pkg::*;
#(
	parameter int BUFFER_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic [3:0]  byte_count,
	input  acdke_cmd_t  cmd,
	output acdke_sts_t  sts,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] random_data,
	output logic        rekeyed
);

	localparam int NROWS = (BUFFER_BYTES + 15) / 16;
	localparam int RW    = $clog2(NROWS);
	localparam int CW    = $clog2(BUFFER_BYTES + 1);
	localparam logic [CW-1:0] CUR_END  = CW'(BUFFER_BYTES);
	localparam logic [CW-1:0] CUR_LAST = CW'(BUFFER_BYTES - 1);
	localparam logic [CW-1:0] CUR_FIRST = CW'(16);
	localparam logic [RW-1:0] ROW_LAST = RW'(NROWS - 1);

	logic [63:0]   seed_lo_q, seed_hi_q;
	logic          seeded_q;
	logic [127:0]  rk_q [11];
	logic [3:0]    kidx_q;
	logic [7:0]    rc_q;
	logic [127:0]  newkey_q;
	logic [127:0]  st_q;
	logic [3:0]    rnd_q;
	logic [RW-1:0] blk_q;
	logic [CW-1:0] cursor_q;
	logic [3:0]    want_q, cnt_q;
	logic [63:0]   data_q;
	logic          rekey_q;
	logic [127:0]  mem [NROWS];
	logic [127:0]  rdata_q;
	logic [127:0]  rnd_out;
	logic [RW-1:0] rd_row;
	logic [CW-5:0] cur_row;

	assign cur_row = cursor_q[CW-1:4];
	assign rd_row  = RW'(cur_row);
	assign rnd_out = (rnd_q == 4'd0) ? ({{(128-RW){1'b0}}, blk_q} ^ rk_q[0])
		: (aes_round(st_q, rnd_q == LAST_ROUND) ^ rk_q[rnd_q]);

	assign sts.seeded     = seeded_q;
	assign sts.kx_last    = (kidx_q == LAST_ROUND);
	assign sts.enc_last   = (rnd_q == LAST_ROUND) && (blk_q == ROW_LAST);
	assign sts.want_done  = (cnt_q == want_q);
	assign sts.take_last  = (cnt_q + 4'd1 == want_q);
	assign sts.cursor_end = (cursor_q >= CUR_END);
	assign sts.row_edge   = (cursor_q[3:0] == 4'hF) || (cursor_q == CUR_LAST);
	assign sts.out_free   = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.enc_step && rnd_q == LAST_ROUND)
			mem[blk_q] <= rnd_out;
		rdata_q <= mem[rd_row];
	end

	always_ff @(posedge clk) begin
		if (cmd.kx_seed) begin
			rk_q[0] <= {seed_hi_q, seed_lo_q};
		end else if (cmd.kx_new) begin
			rk_q[0] <= newkey_q;
		end else if (cmd.kx_step && kidx_q != 4'd0 && kidx_q <= LAST_ROUND) begin
			rk_q[kidx_q] <= next_key(rk_q[kidx_q - 4'd1], rc_q);
		end
		if (cmd.enc_step) begin
			st_q <= rnd_out;
			if (rnd_q == LAST_ROUND && blk_q == '0)
				newkey_q <= rnd_out;
		end
		if (cmd.item_start)
			data_q <= '0;
		else if (cmd.take)
			data_q[{cnt_q[2:0], 3'b000} +: 8] <= rdata_q[{cursor_q[3:0], 3'b000} +: 8];
		if (cmd.out_load) begin
			random_data <= data_q;
			rekeyed     <= rekey_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_lo_q <= '0;
			seed_hi_q <= '0;
			seeded_q  <= 1'b0;
			kidx_q    <= 4'd0;
			rc_q      <= RCON_FIRST;
			rnd_q     <= 4'd0;
			blk_q     <= '0;
			cursor_q  <= CUR_END;
			want_q    <= 4'd0;
			cnt_q     <= 4'd0;
			rekey_q   <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == CFG_KEY_HIGH)
					seed_hi_q <= cfg_data;
				else
					seed_lo_q <= cfg_data;
			end
			if (cmd.kx_seed || cmd.kx_new) begin
				kidx_q <= 4'd1;
				rc_q   <= RCON_FIRST;
				seeded_q <= 1'b1;
			end else if (cmd.kx_step && kidx_q != 4'd0) begin
				kidx_q <= (kidx_q == LAST_ROUND) ? 4'd0 : kidx_q + 4'd1;
				rc_q   <= xtime(rc_q);
			end
			if (cmd.enc_begin) begin
				rnd_q <= 4'd0;
				blk_q <= '0;
			end else if (cmd.enc_step) begin
				if (rnd_q == LAST_ROUND) begin
					rnd_q <= 4'd0;
					blk_q <= (blk_q == ROW_LAST) ? '0 : blk_q + RW'(1);
				end else begin
					rnd_q <= rnd_q + 4'd1;
				end
			end
			if (cmd.item_start) begin
				want_q  <= (byte_count > MAX_REQ) ? MAX_REQ : byte_count;
				cnt_q   <= 4'd0;
				rekey_q <= 1'b0;
			end else begin
				if (cmd.take)
					cnt_q <= cnt_q + 4'd1;
				if (cmd.set_rekeyed)
					rekey_q <= 1'b1;
			end
			if (cmd.set_cursor)
				cursor_q <= CUR_FIRST;
			else if (cmd.take)
				cursor_q <= cursor_q + CW'(1);
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_END) else $error("cursor beyond buffer");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= want_q) else $error("more bytes taken than requested");
	a_kidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		kidx_q <= LAST_ROUND && rnd_q <= LAST_ROUND) else $error("round index overrun");
`endif

endmodule

// File: src/aes128_ctr_drbg_key_erasure.sv
// AES-128 counter-mode random byte generator with fast key erasure.
// Request channel s_*: s_tdata[3:0] is the byte count (1..8, larger saturates
// to 8, zero gives an empty result). Result channel m_*: m_tdata carries the
// issued bytes, first byte lowest; m_tuser is set when the request caused a
// refill and key rotation. Config channel cfg_*: index 0 seed key low half,
// index 1 high half; always ready, to be written while the block is idle.
// The first request after reset expands the seed key. A request reads its
// bytes from the buffer memory, with a pause each time reading crosses a
// 16-byte row of that memory. When the buffer runs dry the request stalls
// for a refill: ceil(BUFFER_BYTES/16) blocks through the single AES round
// unit, then key expansion from the first block.
// Reset leaves the buffer marked exhausted and the generator unseeded.
// One result is held in an output register; a new request is taken while it
// waits, and the block waits before its own result if m_tready stays low.
module aes128_ctr_drbg_key_erasure
	import acdke_pkg::*;
#(
	parameter int BUFFER_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] byte_count, [7:4] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [63:0] random_data
	output logic        m_tuser,   // [0] rekeyed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	acdke_cmd_t cmd;
	acdke_sts_t sts;

	assign cfg_ready = 1'b1;

	acdke_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	acdke_dp #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_count  (s_tdata[3:0]),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.random_data (m_tdata),
		.rekeyed     (m_tuser)
	);

endmodule
